// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the staged parameter table.
// Users must have clk_i and rst_ni in scope; define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked only while out of reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/spt_pkg.sv =====
// Package of the staged parameter table: widths, codes and request structs.
// Used by the interfaces, the storage modules and the top level.
`default_nettype none
package spt_pkg;

  localparam int TABLE_ENTRIES_DEF = 5400;
  localparam int STAGE_DEPTH_DEF   = 16;

  localparam int OPCODE_W  = 2;
  localparam int IDX_W     = 13;
  localparam int WORD_W    = 64;
  localparam int STATUS_W  = 2;
  localparam int PEND_W    = 5;
  // Enough pointer bits for the deepest staging buffer (64 entries).
  localparam int STG_PTR_W = 6;

  typedef enum logic [OPCODE_W-1:0] {
    OP_READ   = 2'd0,
    OP_STAGE  = 2'd1,
    OP_SET    = 2'd2,
    OP_COMMIT = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // Single-port table access: a write when we is set, otherwise a read.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] wdata;
  } tbl_req_t;

  // Staging buffer access: one write and one read address per cycle.
  typedef struct packed {
    logic                 we;
    logic [STG_PTR_W-1:0] waddr;
    logic [IDX_W-1:0]     windex;
    logic [WORD_W-1:0]    wvalue;
    logic [STG_PTR_W-1:0] raddr;
  } stg_req_t;

endpackage
`default_nettype wire

// ===== src/spt_req_if.sv =====
// Request channel of the staged parameter table: valid/ready plus payload.
// Depends on spt_pkg for the field widths.
`default_nettype none
interface spt_req_if;
  logic                         valid;
  logic                         ready;
  logic [spt_pkg::OPCODE_W-1:0] opcode;
  logic [spt_pkg::IDX_W-1:0]    entry_index;
  logic [spt_pkg::WORD_W-1:0]   entry_value;

  modport source (output valid, output opcode, output entry_index, output entry_value,
                  input ready);
  modport sink   (input valid, input opcode, input entry_index, input entry_value,
                  output ready);
endinterface
`default_nettype wire

// ===== src/spt_rsp_if.sv =====
// Response channel of the staged parameter table: valid/ready plus payload.
// Depends on spt_pkg for the field widths.
`default_nettype none
interface spt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [spt_pkg::STATUS_W-1:0] status;
  logic [spt_pkg::WORD_W-1:0]   read_data;
  logic [spt_pkg::PEND_W-1:0]   pending_after;

  modport source (output valid, output status, output read_data, output pending_after,
                  input ready);
  modport sink   (input valid, input status, input read_data, input pending_after,
                  output ready);
endinterface
`default_nettype wire

// ===== src/spt_table_mem.sv =====
// Single-port table memory of 64-bit words with registered read data.
// Depends on spt_pkg for the request struct.
`default_nettype none
module spt_table_mem #(
  parameter int TABLE_ENTRIES = spt_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                       clk_i,
  input  wire spt_pkg::tbl_req_t          req_i,
  output logic [spt_pkg::WORD_W-1:0]      rd_data_o
);

  localparam int AW = $clog2(TABLE_ENTRIES);

  logic [spt_pkg::WORD_W-1:0] mem [TABLE_ENTRIES];
  logic [spt_pkg::WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr[AW-1:0]] <= req_i.wdata;
    end else begin
      rd_data_q <= mem[req_i.addr[AW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// ===== src/spt_stage_buf.sv =====
// Staging buffer of index/value pairs, one write and one registered read per cycle.
// Depends on spt_pkg for the request struct.
`default_nettype none
module spt_stage_buf #(
  parameter int STAGE_DEPTH = spt_pkg::STAGE_DEPTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire spt_pkg::stg_req_t          req_i,
  output logic [spt_pkg::IDX_W-1:0]       rd_index_o,
  output logic [spt_pkg::WORD_W-1:0]      rd_value_o
);

  localparam int SPW = (STAGE_DEPTH > 1) ? $clog2(STAGE_DEPTH) : 1;

  logic [spt_pkg::IDX_W-1:0]  idx_mem [STAGE_DEPTH];
  logic [spt_pkg::WORD_W-1:0] val_mem [STAGE_DEPTH];
  logic [spt_pkg::IDX_W-1:0]  rd_index_q;
  logic [spt_pkg::WORD_W-1:0] rd_value_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      idx_mem[req_i.waddr[SPW-1:0]] <= req_i.windex;
      val_mem[req_i.waddr[SPW-1:0]] <= req_i.wvalue;
    end
    rd_index_q <= idx_mem[req_i.raddr[SPW-1:0]];
    rd_value_q <= val_mem[req_i.raddr[SPW-1:0]];
  end

  assign rd_index_o = rd_index_q;
  assign rd_value_o = rd_value_q;

endmodule
`default_nettype wire

// ===== src/staged_parameter_table.sv =====
// Staged parameter table. After reset the table is cleared, one word a cycle, and no
// request is taken during the clearing pass. Stage, direct set and an empty commit respond
// in the cycle after acceptance; a read passes through the registered memory read and the
// S_READ state; a commit of n pending pairs first fetches the first staged pair, then
// does one table write per pair on the single table port. One request is in work at a
// time, and the next is taken no earlier than the cycle its predecessor's response is taken.
`default_nettype none
`include "assert_macros.svh"
module staged_parameter_table #(
  parameter int TABLE_ENTRIES = spt_pkg::TABLE_ENTRIES_DEF,
  parameter int STAGE_DEPTH   = spt_pkg::STAGE_DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spt_req_if.sink    req_i,
  spt_rsp_if.source  rsp_o
);

  // Table address bits, staging count bits (must hold STAGE_DEPTH itself) and pointer bits.
  localparam int AW  = $clog2(TABLE_ENTRIES);
  localparam int CW  = $clog2(STAGE_DEPTH + 1);
  localparam int SPW = (STAGE_DEPTH > 1) ? $clog2(STAGE_DEPTH) : 1;
  localparam int IW  = spt_pkg::IDX_W;
  localparam int IW1 = spt_pkg::IDX_W + 1;
  localparam int PW  = spt_pkg::PEND_W;
  localparam int GW  = spt_pkg::STG_PTR_W;

  localparam logic [AW-1:0]  CLR_LAST  = AW'(TABLE_ENTRIES - 1);
  localparam logic [IW1-1:0] IDX_LIMIT = IW1'(TABLE_ENTRIES);
  localparam logic [CW-1:0]  CNT_FULL  = CW'(STAGE_DEPTH);

  // The sequencer: clearing after reset, waiting for a request, finishing a read, and
  // walking the staging buffer during a commit.
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_COMMIT
  } state_e;

  state_e                     state_q;
  logic [AW-1:0]              clr_cnt_q;
  logic [CW-1:0]              cnt_q;
  logic [CW-1:0]              ptr_q;
  logic                       wr_pend_q;
  logic                       rd_ok_q;
  logic                       out_valid_q;
  spt_pkg::status_e           out_status_q;
  logic [spt_pkg::WORD_W-1:0] out_data_q;
  logic [PW-1:0]              out_pend_q;

  spt_pkg::tbl_req_t          tbl_req;
  spt_pkg::stg_req_t          stg_req;
  logic [spt_pkg::WORD_W-1:0] tbl_rdata;
  logic [IW-1:0]              stg_rd_index;
  logic [spt_pkg::WORD_W-1:0] stg_rd_value;

  logic          accept;
  logic          slot_free;
  logic          idx_in_range;
  logic          idx_nonzero;
  logic          idx_writable;
  logic          stage_full;
  logic          stage_we;
  logic [CW-1:0] cnt_inc;

  // The output register frees up in the same cycle its response is taken, so a new
  // request can be accepted while the previous response is being handed over.
  assign slot_free       = !out_valid_q || rsp_o.ready;
  assign req_i.ready     = (state_q == S_IDLE) && slot_free;
  assign accept          = req_i.valid && req_i.ready;

  // Index checks shared by read, stage and direct set. The compare is one bit wider
  // than the index so a table of 8192 entries still works.
  assign idx_in_range = ({1'b0, req_i.entry_index} < IDX_LIMIT);
  assign idx_nonzero  = (req_i.entry_index != '0);
  assign idx_writable = idx_in_range && idx_nonzero;
  assign stage_full   = (cnt_q == CNT_FULL);
  assign cnt_inc      = cnt_q + CW'(1);

  assign stage_we = accept && (spt_pkg::opcode_e'(req_i.opcode) == spt_pkg::OP_STAGE) &&
                    idx_writable && !stage_full;

  // Staging buffer: new pairs go to the slot at the current count; a commit reads
  // them back in order through the commit pointer.
  always_comb begin
    stg_req.we     = stage_we;
    stg_req.waddr  = GW'(cnt_q[SPW-1:0]);
    stg_req.windex = req_i.entry_index;
    stg_req.wvalue = req_i.entry_value;
    stg_req.raddr  = GW'(ptr_q[SPW-1:0]);
  end

  // The single table port is shared by the clearing pass, direct sets, reads and the
  // commit walk; the sequencer state decides who owns it.
  always_comb begin
    tbl_req.we    = 1'b0;
    tbl_req.addr  = req_i.entry_index;
    tbl_req.wdata = req_i.entry_value;
    case (state_q)
      S_CLEAR: begin
        tbl_req.we    = 1'b1;
        tbl_req.addr  = IW'(clr_cnt_q);
        tbl_req.wdata = '0;
      end
      S_IDLE: begin
        tbl_req.we = accept && idx_writable &&
                     (spt_pkg::opcode_e'(req_i.opcode) == spt_pkg::OP_SET);
      end
      S_COMMIT: begin
        // Staged indices were checked when they were staged, so they are writable.
        tbl_req.we    = wr_pend_q;
        tbl_req.addr  = stg_rd_index;
        tbl_req.wdata = stg_rd_value;
      end
      default: begin
        tbl_req.we = 1'b0;
      end
    endcase
  end

  spt_table_mem #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk_i     (clk_i),
    .req_i     (tbl_req),
    .rd_data_o (tbl_rdata)
  );

  spt_stage_buf #(
    .STAGE_DEPTH (STAGE_DEPTH)
  ) u_stage (
    .clk_i      (clk_i),
    .req_i      (stg_req),
    .rd_index_o (stg_rd_index),
    .rd_value_o (stg_rd_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_cnt_q    <= '0;
      cnt_q        <= '0;
      ptr_q        <= '0;
      wr_pend_q    <= 1'b0;
      rd_ok_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= spt_pkg::ST_OK;
      out_data_q   <= '0;
      out_pend_q   <= '0;
    end else begin
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == CLR_LAST) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (spt_pkg::opcode_e'(req_i.opcode))
              spt_pkg::OP_READ: begin
                // The word comes out of the memory next cycle.
                state_q      <= S_READ;
                rd_ok_q      <= idx_writable;
                out_status_q <= idx_in_range ? spt_pkg::ST_OK : spt_pkg::ST_BAD_INDEX;
              end
              spt_pkg::OP_STAGE: begin
                out_valid_q <= 1'b1;
                out_data_q  <= '0;
                // The index check wins over the full check.
                if (!idx_writable) begin
                  out_status_q <= spt_pkg::ST_BAD_INDEX;
                end else if (stage_full) begin
                  out_status_q <= spt_pkg::ST_FULL;
                end else begin
                  out_status_q <= spt_pkg::ST_OK;
                end
                if (stage_we) begin
                  cnt_q      <= cnt_inc;
                  out_pend_q <= PW'(cnt_inc);
                end else begin
                  out_pend_q <= PW'(cnt_q);
                end
              end
              spt_pkg::OP_SET: begin
                out_valid_q  <= 1'b1;
                out_data_q   <= '0;
                out_status_q <= idx_writable ? spt_pkg::ST_OK : spt_pkg::ST_BAD_INDEX;
                out_pend_q   <= PW'(cnt_q);
              end
              spt_pkg::OP_COMMIT: begin
                ptr_q     <= '0;
                wr_pend_q <= 1'b0;
                if (cnt_q == '0) begin
                  out_valid_q  <= 1'b1;
                  out_data_q   <= '0;
                  out_status_q <= spt_pkg::ST_OK;
                  out_pend_q   <= '0;
                end else begin
                  state_q <= S_COMMIT;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_READ: begin
          out_valid_q <= 1'b1;
          out_data_q  <= rd_ok_q ? tbl_rdata : '0;
          out_pend_q  <= PW'(cnt_q);
          state_q     <= S_IDLE;
        end
        S_COMMIT: begin
          // Each buffer read is registered, and the table write of that pair follows in the next
          // cycle. The last write lands in the same cycle the response is loaded.
          if (ptr_q < cnt_q) begin
            ptr_q     <= ptr_q + CW'(1);
            wr_pend_q <= 1'b1;
          end else begin
            wr_pend_q <= 1'b0;
            if (wr_pend_q) begin
              cnt_q        <= '0;
              out_valid_q  <= 1'b1;
              out_data_q   <= '0;
              out_status_q <= spt_pkg::ST_OK;
              out_pend_q   <= '0;
              state_q      <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.read_data     = out_data_q;
  assign rsp_o.pending_after = out_pend_q;

  // The pending count never runs past the buffer depth.
  `ASSERT_RST(a_cnt_bound, cnt_q <= CNT_FULL, "staging count exceeds buffer depth")
  // Nothing is accepted while the table is being cleared.
  `ASSERT_ALWAYS(a_no_accept_clear, (state_q == S_CLEAR) |-> !req_i.ready, "request taken during clear")
  // Entry zero is never written once clearing is over.
  `ASSERT_RST(a_no_write_zero, ((state_q != S_CLEAR) && tbl_req.we) |-> (tbl_req.addr != '0), "write to entry zero")
  // A commit in progress never has a response waiting in the output register.
  `ASSERT_RST(a_commit_slot, (state_q == S_COMMIT) |-> !out_valid_q, "response pending during commit")

endmodule
`default_nettype wire

// ===== test/param_table_checker.sv =====
`timescale 1ns / 1ps
// Checker for the staged parameter table: watches the request and response channels,
// keeps a shadow copy of the table and the staging buffer, and compares each response.
// Depends on spt_pkg and on the spt_req_if and spt_rsp_if interfaces.
module param_table_checker #(
  parameter int TABLE_ENTRIES = spt_pkg::TABLE_ENTRIES_DEF,
  parameter int STAGE_DEPTH   = spt_pkg::STAGE_DEPTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  spt_req_if          req_i,
  spt_rsp_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);
  import spt_pkg::*;

  typedef struct packed {
    status_e             status;
    logic [WORD_W-1:0]   read_data;
    logic [PEND_W-1:0]   pending_after;
  } table_result_t;

  logic [WORD_W-1:0] shadow_words [TABLE_ENTRIES];
  logic [IDX_W-1:0]  staged_idx   [STAGE_DEPTH];
  logic [WORD_W-1:0] staged_word  [STAGE_DEPTH];
  int unsigned       staged_cnt;
  table_result_t     expected_rsp_q [$];

  task automatic report_error(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic bit writable(input logic [IDX_W-1:0] idx);
    return idx != '0 && idx < TABLE_ENTRIES;
  endfunction

  // Applies one request to the shadow state and returns the response it must produce.
  function automatic table_result_t apply_request(input opcode_e op,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic [WORD_W-1:0] word);
    table_result_t res;
    res.status    = ST_OK;
    res.read_data = '0;
    case (op)
      OP_READ: begin
        if (idx >= TABLE_ENTRIES) res.status = ST_BAD_INDEX;
        else if (idx != '0) res.read_data = shadow_words[idx];
      end
      OP_STAGE: begin
        // The index check wins over the full check.
        if (!writable(idx)) begin
          res.status = ST_BAD_INDEX;
        end else if (staged_cnt >= STAGE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          staged_idx[staged_cnt]  = idx;
          staged_word[staged_cnt] = word;
          staged_cnt++;
        end
      end
      OP_SET: begin
        if (!writable(idx)) res.status = ST_BAD_INDEX;
        else shadow_words[idx] = word;
      end
      default: begin
        // In staging order, so a later pair to the same entry wins.
        for (int k = 0; k < staged_cnt; k++) shadow_words[staged_idx[k]] = staged_word[k];
        staged_cnt = 0;
      end
    endcase
    res.pending_after = PEND_W'(staged_cnt);
    return res;
  endfunction

  always @(posedge clk_i) begin
    table_result_t want;
    if (!rst_ni) begin
      for (int k = 0; k < TABLE_ENTRIES; k++) shadow_words[k] = '0;
      staged_cnt = 0;
      expected_rsp_q.delete();
      fail_count_o = 0;
      outstanding_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_error($sformatf("response with no request waiting: status %0d data %h",
                                 rsp_i.status, rsp_i.read_data));
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_i.status !== want.status)
            report_error($sformatf("status %0d, expected %0d", rsp_i.status, want.status));
          if (rsp_i.read_data !== want.read_data)
            report_error($sformatf("read_data %h, expected %h", rsp_i.read_data,
                                   want.read_data));
          if (rsp_i.pending_after !== want.pending_after)
            report_error($sformatf("pending_after %0d, expected %0d", rsp_i.pending_after,
                                   want.pending_after));
        end
      end
      if (req_i.valid && req_i.ready)
        expected_rsp_q.push_back(apply_request(opcode_e'(req_i.opcode), req_i.entry_index,
                                               req_i.entry_value));
      outstanding_o <= expected_rsp_q.size();
    end
  end

endmodule

// ===== test/tb_staged_parameter_table.sv =====
`timescale 1ns / 1ps
// Top of the staged parameter table testbench: clock, reset, request stimulus and the
// response-side backpressure. Depends on spt_pkg, the channel interfaces, the block itself
// and param_table_checker, which does all prediction and comparison.
module tb_staged_parameter_table;
  import spt_pkg::*;

  localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int STAGE_DEPTH   = STAGE_DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 500;
  // The longest request is a commit of a full buffer, plus the output register. After the
  // last response we sit a little longer than that so that a stray extra response still
  // gets caught.
  localparam int TAIL_CYCLES   = STAGE_DEPTH + 4;
  // Reset clearing covers every table entry. After that, roughly 530 requests at worst a
  // full commit each, stretched by sender gaps and response stalls, stay far below this
  // limit.
  localparam int LIMIT_CYCLES  = 300000;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  // While set, neither the sender nor the response side idles.
  logic        steady_run = 1'b0;
  int unsigned sent_total = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned fail_count;
  int unsigned outstanding;

  spt_req_if req_ch ();
  spt_rsp_if rsp_ch ();

  staged_parameter_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .STAGE_DEPTH  (STAGE_DEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  param_table_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .STAGE_DEPTH  (STAGE_DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog. A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Response backpressure: ready drops about 6 percent of the time, except in the
  // steady stretch.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_ch.ready <= steady_run || ($urandom_range(99) >= 6);
    end
  end

  // Sends one request. Random gaps come first, then valid is held until the block takes
  // the request. We return at the edge that accepted it, so the next call can keep valid
  // high without a bubble.
  task automatic send_request(input opcode_e op, input logic [IDX_W-1:0] idx,
                              input logic [WORD_W-1:0] word);
    while (!steady_run && $urandom_range(99) < 6) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.opcode      <= op;
    req_ch.entry_index <= idx;
    req_ch.entry_value <= word;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sent_total++;
  endtask

  // Drops valid and waits until every request sent so far has its response. The checker
  // updates its count at each edge, so we let an edge pass before we look at it.
  task automatic wait_for_drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Most indexes land in a small pool at both ends of the table, so that reads find
  // data that was written. The rest hit entry zero, the range past the table, or anything.
  function automatic logic [IDX_W-1:0] pick_entry();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return IDX_W'($urandom_range(1, 12));
    if (r < 70) return IDX_W'($urandom_range(TABLE_ENTRIES - 4, TABLE_ENTRIES - 1));
    if (r < 80) return '0;
    if (r < 90) return IDX_W'($urandom_range(TABLE_ENTRIES, (1 << IDX_W) - 1));
    return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  initial begin : stimulus
    int unsigned random_base;
    int unsigned done_cnt;
    int unsigned kind;
    int unsigned burst;
    int unsigned r;
    opcode_e     op;
    bit          paused_once;

    paused_once        = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.opcode      = OP_READ;
    req_ch.entry_index = '0;
    req_ch.entry_value = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Entry zero reads as zero; the highest index is out of range for a
    // read; writes to entry zero or past the table are refused; the last entry takes an
    // all-ones word; a commit with nothing staged is harmless.
    send_request(OP_READ,   '0,                          '1);
    send_request(OP_READ,   '1,                          '0);
    send_request(OP_SET,    '0,                          '1);
    send_request(OP_SET,    IDX_W'(TABLE_ENTRIES),       '1);
    send_request(OP_SET,    IDX_W'(TABLE_ENTRIES - 1),   '1);
    send_request(OP_READ,   IDX_W'(TABLE_ENTRIES - 1),   '0);
    send_request(OP_COMMIT, '1,                          '1);
    // Fill the staging buffer with repeated indexes, the last pair to entry 2 being all
    // ones, so the commit shows that the later write wins.
    for (int k = 0; k < STAGE_DEPTH; k++)
      send_request(OP_STAGE, IDX_W'(2 + (k % 5)),
                   (k == STAGE_DEPTH - 1) ? '1 : (k == 0) ? '0 : {$urandom, $urandom});
    // Buffer full: a good index is dropped, a bad one still reports the bad index.
    send_request(OP_STAGE,  IDX_W'(TABLE_ENTRIES - 1),   '0);
    send_request(OP_STAGE,  '0,                          '1);
    send_request(OP_COMMIT, '0,                          '0);
    send_request(OP_READ,   IDX_W'(2 + ((STAGE_DEPTH - 1) % 5)), '0);
    send_request(OP_READ,   IDX_W'(6),                   '0);

    // Random part, built from short episodes: single mixed requests, staged bursts that
    // end in a commit and a read-back (some long enough to overflow the buffer), runs of
    // direct sets, and plain noise over every field.
    random_base = sent_total;
    while (sent_total - random_base < RANDOM_ITEMS) begin
      done_cnt = sent_total - random_base;
      steady_run <= (done_cnt >= 100 && done_cnt < 220);
      // Once, let the block run dry before going on.
      if (!paused_once && done_cnt >= 260) begin
        paused_once = 1'b1;
        wait_for_drain();
      end
      kind = $urandom_range(9);
      if (kind <= 5) begin
        r  = $urandom_range(99);
        op = (r < 35) ? OP_READ : (r < 70) ? OP_STAGE : (r < 88) ? OP_SET : OP_COMMIT;
        send_request(op, pick_entry(), pick_word());
      end else if (kind <= 7) begin
        burst = $urandom_range(1, STAGE_DEPTH + 2);
        repeat (burst) send_request(OP_STAGE, pick_entry(), pick_word());
        send_request(OP_COMMIT, pick_entry(), pick_word());
        repeat (2) send_request(OP_READ, pick_entry(), pick_word());
      end else if (kind == 8) begin
        repeat (3) send_request(OP_SET, pick_entry(), pick_word());
        send_request(OP_READ, pick_entry(), pick_word());
      end else begin
        send_request(opcode_e'($urandom_range(3)), IDX_W'($urandom_range(0, (1 << IDX_W) - 1)),
                     {$urandom, $urandom});
      end
    end
    steady_run <= 1'b0;

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    // Read the failure count away from the clock edge, where the checker updates it.
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
